@@ rtl/aes128_first_round_unit_assert.svh @@
// assertion macros for the aes first round unit
// no dependencies; clock and reset are passed in by the caller
`ifndef AES128_FIRST_ROUND_UNIT_ASSERT_SVH
`define AES128_FIRST_ROUND_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// same-cycle implication, checked outside reset
`define A1R_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication, checked outside reset
`define A1R_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define A1R_ASSERT_NOW(label, clk, rst, ante, cons)
`define A1R_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

@@ rtl/aes1r_pkg.sv @@
// constants and round functions for the aes first round unit
// s-box table, gf(2^8) helpers, mixcolumns and the round key one schedule step
`default_nettype none

package aes1r_pkg;

   // csr port
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 64;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_HIGH = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_LOW  = 2'd1;

   // gf(2^8) reduction and round constant
   localparam logic [7:0] RED_POLY = 8'h1B;
   localparam logic [7:0] MSB_MASK = 8'h80;
   localparam logic [7:0] RCON1    = 8'h01;

   typedef logic [7:0] byte_type;

   localparam byte_type SBOX [256] = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   // multiply by x modulo the aes polynomial
   function automatic byte_type xtime8(input byte_type a);
      byte_type r;
      r = {a[6:0], 1'b0};
      if ((a & MSB_MASK) != 8'h00) begin
         r = r ^ RED_POLY;
      end
      return r;
   endfunction

   // substitute each byte of a word
   function automatic logic [31:0] subst_word(input logic [31:0] w);
      return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
   endfunction

   // one mixcolumns column, row 0 in the top byte
   function automatic logic [31:0] mix_column(input logic [31:0] col);
      byte_type a0, a1, a2, a3, x0, x1, x2, x3;
      a0 = col[31:24];
      a1 = col[23:16];
      a2 = col[15:8];
      a3 = col[7:0];
      x0 = xtime8(a0);
      x1 = xtime8(a1);
      x2 = xtime8(a2);
      x3 = xtime8(a3);
      return {x0 ^ x1 ^ a1 ^ a2 ^ a3,
              a0 ^ x1 ^ x2 ^ a2 ^ a3,
              a0 ^ a1 ^ x2 ^ x3 ^ a3,
              x0 ^ a0 ^ a1 ^ a2 ^ x3};
   endfunction

   // round key one from the cipher key, word 0 in the top bits
   function automatic logic [127:0] round_key_one(input logic [127:0] k);
      logic [31:0] w4, w5, w6, w7, t;
      t  = subst_word({k[23:0], k[31:24]}) ^ {RCON1, 24'h000000};
      w4 = k[127:96] ^ t;
      w5 = k[95:64] ^ w4;
      w6 = k[63:32] ^ w5;
      w7 = k[31:0] ^ w6;
      return {w4, w5, w6, w7};
   endfunction

endpackage

`default_nettype wire

@@ rtl/aes128_first_round_unit.sv @@
// an accepted request word is held in the input register, then its result in the result register
// throughput: one word per cycle while rsp_stall is low; an input register and a result register
// hold one word each, so a new request is taken while a result waits if the input register is empty
// reset: synchronous, active high; clears both valid flags and the key to zero
// depends on aes1r_pkg and aes128_first_round_unit_assert.svh
`default_nettype none
`include "aes128_first_round_unit_assert.svh"

module aes128_first_round_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   // configuration
   input  wire logic                                 csr_write,
   input  wire logic [aes1r_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [aes1r_pkg::CSR_DATA_W-1:0]     csr_wdata,
   // request channel
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [63:0]                          req_text_high,
   input  wire logic [63:0]                          req_text_low,
   // response channel
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [63:0]                               rsp_state_high,
   output logic [63:0]                               rsp_state_low
);

   logic [63:0]  key_high_ff, key_high_in;
   logic [63:0]  key_low_ff, key_low_in;
   logic         in_valid_ff, in_valid_in;
   logic [127:0] text_ff, text_in;
   logic         out_valid_ff, out_valid_in;
   logic [127:0] state_ff, state_in;

   logic         out_load;
   logic         in_advance;
   logic         req_accept;

   aes1r_pkg::byte_type sb_bytes [16];
   aes1r_pkg::byte_type sh_bytes [16];
   logic [127:0] key_full;
   logic [127:0] mixed;
   logic [127:0] round_key;

   // key registers
   always_comb begin
      key_high_in = key_high_ff;
      key_low_in  = key_low_ff;
      if (csr_write) begin
         unique case (csr_index)
            aes1r_pkg::CSR_KEY_HIGH: key_high_in = csr_wdata;
            aes1r_pkg::CSR_KEY_LOW:  key_low_in  = csr_wdata;
            default: ;
         endcase
      end
   end

   // pipeline flow control
   assign out_load   = !out_valid_ff || !rsp_stall;
   assign in_advance = in_valid_ff && out_load;
   assign req_stall  = in_valid_ff && !out_load;
   assign req_accept = req_valid && !req_stall;

   always_comb begin
      in_valid_in  = req_accept || (in_valid_ff && !out_load);
      text_in      = req_accept ? {req_text_high, req_text_low} : text_ff;
      out_valid_in = out_load ? in_valid_ff : out_valid_ff;
   end

   // initial addroundkey and subbytes, one s-box per byte
   assign key_full = {key_high_ff, key_low_ff};

   always_comb begin
      for (int n = 0; n < 16; n++) begin
         sb_bytes[n] = aes1r_pkg::SBOX[text_ff[127-8*n -: 8] ^ key_full[127-8*n -: 8]];
      end
   end

   // shiftrows: row r rotates left by r columns
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            sh_bytes[4*c+r] = sb_bytes[4*((c + r) % 4) + r];
         end
      end
   end

   // mixcolumns per column
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         mixed[127-32*c -: 32] = aes1r_pkg::mix_column(
            {sh_bytes[4*c], sh_bytes[4*c+1], sh_bytes[4*c+2], sh_bytes[4*c+3]});
      end
   end

   // final addroundkey with round key one
   assign round_key = aes1r_pkg::round_key_one(key_full);

   always_comb begin
      state_in = in_advance ? (mixed ^ round_key) : state_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         key_high_ff  <= '0;
         key_low_ff   <= '0;
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         key_high_ff  <= key_high_in;
         key_low_ff   <= key_low_in;
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      text_ff  <= text_in;
      state_ff <= state_in;
   end

   assign rsp_valid      = out_valid_ff;
   assign rsp_state_high = state_ff[127:64];
   assign rsp_state_low  = state_ff[63:0];

   // checks
   `A1R_ASSERT_NEXT(a_accept_fills_input, clock, reset, req_accept, in_valid_ff)
   `A1R_ASSERT_NEXT(a_advance_fills_output, clock, reset, in_advance, out_valid_ff)
   `A1R_ASSERT_NEXT(a_held_word_kept, clock, reset, in_valid_ff && !out_load,
      in_valid_ff && $stable(text_ff))
   `A1R_ASSERT_NOW(a_stall_only_when_full, clock, reset, req_stall,
      in_valid_ff && out_valid_ff && rsp_stall)

endmodule

`default_nettype wire

@@ tb/sv/aes128_first_round_unit_test.sv @@
// self-checking bench for aes128_first_round_unit: known vectors, then random words
// under several keys, compared with a first-round predictor built from gf(2^8) maths
// depends on aes1r_pkg for the csr index constants and widths
`default_nettype none

module aes128_first_round_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   // indexes with no register behind them
   localparam logic [aes1r_pkg::CSR_INDEX_W-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [aes1r_pkg::CSR_INDEX_W-1:0] CSR_SPARE_B = 2'd3;

   localparam logic [7:0] AES_POLY  = 8'h1B;
   localparam logic [7:0] AFFINE_C  = 8'h63;
   localparam logic [7:0] RCON_ONE  = 8'h01;

   localparam int RANDOM_WORDS  = 1700;
   localparam int QUIET_TAIL    = 300;
   localparam int SETTLE_CYCLES = 4;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int REPORT_MAX    = 10;

   // standard test keys and blocks
   localparam logic [127:0] KEY_SEQ   = 128'h000102030405060708090a0b0c0d0e0f;
   localparam logic [127:0] TEXT_SEQ  = 128'h00112233445566778899aabbccddeeff;
   localparam logic [127:0] KEY_STD   = 128'h2b7e151628aed2a6abf7158809cf4f3c;
   localparam logic [127:0] TEXT_STD  = 128'h3243f6a8885a308d313198a2e0370734;
   localparam logic [127:0] ALL_ZERO  = 128'h0;
   localparam logic [127:0] ALL_ONE   = {128{1'b1}};
   localparam logic [127:0] CHECKER_A = {32{4'ha}};
   localparam logic [127:0] CHECKER_5 = {32{4'h5}};

   typedef struct packed {
      logic [127:0] key;
      logic [127:0] text;
      logic         known;
      logic [127:0] state;
   } vector_row_type;

   localparam int PLAN_ROWS = 17;

   // directed vectors, grouped by key; known states are typed in
   localparam vector_row_type plan [PLAN_ROWS] = '{
      '{ALL_ZERO, ALL_ZERO, 1'b1, 128'h01000000010000000100000001000000},
      '{ALL_ZERO, ALL_ONE, 1'b0, ALL_ZERO},
      '{ALL_ZERO, CHECKER_A, 1'b0, ALL_ZERO},
      '{ALL_ZERO, CHECKER_5, 1'b0, ALL_ZERO},
      '{ALL_ZERO, 128'h80000000000000000000000000000001, 1'b0, ALL_ZERO},
      '{ALL_ZERO, 128'h00000000000000018000000000000000, 1'b0, ALL_ZERO},
      '{ALL_ONE, ALL_ONE, 1'b1, 128'h8b8a8a8a747575758b8a8a8a74757575},
      '{ALL_ONE, ALL_ZERO, 1'b0, ALL_ZERO},
      '{ALL_ONE, 128'h0123456789abcdeffedcba9876543210, 1'b0, ALL_ZERO},
      '{KEY_SEQ, TEXT_SEQ, 1'b1, 128'h89d810e8855ace682d1843d8cb128fe4},
      '{KEY_SEQ, ALL_ZERO, 1'b0, ALL_ZERO},
      '{KEY_SEQ, ALL_ONE, 1'b0, ALL_ZERO},
      '{KEY_STD, TEXT_STD, 1'b1, 128'ha49c7ff2689f352b6b5bea43026a5049},
      '{KEY_STD, KEY_STD, 1'b0, ALL_ZERO},
      '{CHECKER_A, CHECKER_5, 1'b0, ALL_ZERO},
      '{CHECKER_A, CHECKER_A, 1'b0, ALL_ZERO},
      '{128'h80000000000000000000000000000001,
        128'h7ffffffffffffffffffffffffffffffe, 1'b0, ALL_ZERO}
   };

   logic                                  clock = 1'b0;
   logic                                  reset;
   logic                                  csr_write;
   logic [aes1r_pkg::CSR_INDEX_W-1:0]     csr_index;
   logic [aes1r_pkg::CSR_DATA_W-1:0]      csr_wdata;
   logic                                  req_valid;
   logic                                  req_stall;
   logic [63:0]                           req_text_high;
   logic [63:0]                           req_text_low;
   logic                                  rsp_valid;
   logic                                  rsp_stall;
   logic [63:0]                           rsp_state_high;
   logic [63:0]                           rsp_state_low;

   aes128_first_round_unit uut (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_text_high  (req_text_high),
      .req_text_low   (req_text_low),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_state_high (rsp_state_high),
      .rsp_state_low  (rsp_state_low)
   );

   always #4 clock = ~clock;

   logic [7:0]   sub_table [256];
   logic [127:0] expected_states [$];
   logic [127:0] cipher_key;   // key as the block should hold it
   logic [127:0] key_now;      // key most recently programmed by the stimulus
   logic         next_known;
   logic [127:0] next_state;
   logic         idle_on;
   int           fail_count;
   int           cycle_count;
   int           words_sent;
   int           responses_checked;
   int           key_settings;
   int           stall_left;

   // gf(2^8) doubling with the aes reduction
   function automatic logic [7:0] gf_double(input logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? AES_POLY : 8'h00);
   endfunction

   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [7:0] acc;
      logic [7:0] x;
      acc = 8'h00;
      x = a;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) acc = acc ^ x;
         x = gf_double(x);
      end
      return acc;
   endfunction

   // s-box from the field inverse and the affine map
   task automatic fill_sub_table();
      logic [7:0] inv;
      for (int v = 0; v < 256; v++) begin
         inv = 8'h01;
         for (int e = 0; e < 254; e++) inv = gf_mul(inv, 8'(v));
         if (v == 0) inv = 8'h00;
         sub_table[v] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                        ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ AFFINE_C;
      end
   endtask

   // whitening, sub bytes, shift rows, mix columns and round key one
   function automatic logic [127:0] round_one(input logic [127:0] key,
                                              input logic [127:0] text);
      logic [7:0]   k  [16];
      logic [7:0]   s  [16];
      logic [7:0]   rk [16];
      logic [7:0]   a  [4];
      logic [7:0]   col;
      logic [127:0] result;
      for (int n = 0; n < 16; n++) begin
         k[n] = key[127-8*n -: 8];
         s[n] = sub_table[k[n] ^ text[127-8*n -: 8]];
      end
      for (int j = 0; j < 4; j++)
         rk[j] = k[j] ^ sub_table[k[12 + (j + 1) % 4]] ^ (j == 0 ? RCON_ONE : 8'h00);
      for (int j = 4; j < 16; j++) rk[j] = k[j] ^ rk[j-4];
      for (int c = 0; c < 4; c++) begin
         // shift rows folded into the column fetch
         for (int r = 0; r < 4; r++) a[r] = s[4*((c + r) % 4) + r];
         for (int r = 0; r < 4; r++) begin
            col = gf_double(a[r]) ^ gf_double(a[(r+1)%4]) ^ a[(r+1)%4]
                  ^ a[(r+2)%4] ^ a[(r+3)%4];
            result[127-8*(4*c+r) -: 8] = col ^ rk[4*c+r];
         end
      end
      return result;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic flag_failure(input string what);
      fail_count++;
      if (fail_count <= REPORT_MAX) $display("error at cycle %0d: %s", cycle_count, what);
   endtask

   // response checking, key tracking and expectation capture on each rising edge
   always @(posedge clock) begin
      logic [127:0] want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
                  expected_states.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
      if (reset) begin
         cipher_key = ALL_ZERO;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_states.size() == 0) begin
               flag_failure($sformatf("response word %h_%h with nothing expected",
                                      rsp_state_high, rsp_state_low));
            end else begin
               want = expected_states.pop_front();
               responses_checked++;
               if (rsp_state_high !== want[127:64])
                  flag_failure($sformatf("state_high expected %h got %h",
                                         want[127:64], rsp_state_high));
               if (rsp_state_low !== want[63:0])
                  flag_failure($sformatf("state_low expected %h got %h",
                                         want[63:0], rsp_state_low));
            end
         end
         if (req_valid && !req_stall)
            expected_states.insert(expected_states.size(), next_known ? next_state :
                                   round_one(cipher_key, {req_text_high, req_text_low}));
         if (csr_write) begin
            case (csr_index)
               aes1r_pkg::CSR_KEY_HIGH: cipher_key[127:64] = csr_wdata;
               aes1r_pkg::CSR_KEY_LOW:  cipher_key[63:0]   = csr_wdata;
               default: ;
            endcase
         end
      end
   end

   // response back-pressure in random bursts
   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_stall <= 1'b1;
         stall_left = $urandom_range(0, 9);
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // stop sending and wait for every outstanding word
   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_states.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [aes1r_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [63:0] data);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // program a key while idle; a stray write to a spare index must be ignored
   task automatic set_key(input logic [127:0] k);
      drain();
      write_csr(aes1r_pkg::CSR_KEY_HIGH, k[127:64]);
      write_csr(aes1r_pkg::CSR_KEY_LOW, k[63:0]);
      write_csr($urandom_range(0, 1) ? CSR_SPARE_A : CSR_SPARE_B, rand64());
      @(negedge clock);
      csr_write <= 1'b0;
      key_now = k;
      key_settings++;
   endtask

   // offer one word, with an optional idle burst in front
   task automatic send_word(input logic [127:0] text, input logic known,
                            input logic [127:0] state);
      int gap;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 10);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      next_known = known;
      next_state = state;
      req_valid <= 1'b1;
      req_text_high <= text[127:64];
      req_text_low <= text[63:0];
      do @(posedge clock); while (req_stall);
      words_sent++;
   endtask

   // random text with a share of edge patterns against the current key
   function automatic logic [127:0] pick_text(input logic [127:0] k);
      case ($urandom_range(0, 15))
         0: return ALL_ZERO;
         1: return ALL_ONE;
         2: return k;
         3: return ~k;
         4: return 128'h1 << $urandom_range(0, 127);
         default: return {rand64(), rand64()};
      endcase
   endfunction

   initial begin
      vector_row_type row;
      logic [127:0]   key_pick;
      int             random_sent;
      int             phase_len;
      reset = 1'b1;
      csr_write = 1'b0;
      csr_index = aes1r_pkg::CSR_KEY_HIGH;
      csr_wdata = '0;
      req_valid = 1'b0;
      req_text_high = '0;
      req_text_low = '0;
      rsp_stall = 1'b0;
      next_known = 1'b0;
      next_state = '0;
      idle_on = 1'b0;
      cipher_key = '0;
      key_now = '0;
      fail_count = 0;
      cycle_count = 0;
      words_sent = 0;
      responses_checked = 0;
      key_settings = 0;
      stall_left = 0;
      random_sent = 0;
      fill_sub_table();

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed vectors
      idle_on = 1'b1;
      for (int i = 0; i < PLAN_ROWS; i++) begin
         row = plan[i];
         if (i == 0 || row.key != key_now) set_key(row.key);
         send_word(row.text, row.known, row.state);
      end

      // random phases, each under its own key; phases starting in the quiet tail run without idling
      while (random_sent < RANDOM_WORDS) begin
         case ($urandom_range(0, 7))
            0: key_pick = ALL_ZERO;
            1: key_pick = ALL_ONE;
            2: key_pick = $urandom_range(0, 1) ? CHECKER_A : CHECKER_5;
            3: key_pick = {key_now[127:64], rand64()};
            4: key_pick = {rand64(), key_now[63:0]};
            default: key_pick = {rand64(), rand64()};
         endcase
         set_key(key_pick);
         idle_on = (random_sent + QUIET_TAIL < RANDOM_WORDS) && ($urandom_range(0, 3) != 0);
         phase_len = $urandom_range(80, 200);
         if (phase_len > RANDOM_WORDS - random_sent) phase_len = RANDOM_WORDS - random_sent;
         for (int i = 0; i < phase_len; i++) begin
            if ($urandom_range(0, 99) == 0) drain();
            send_word(pick_text(key_now), 1'b0, ALL_ZERO);
            random_sent++;
         end
      end

      drain();
      $display("%0d words sent under %0d key settings (%0d table vectors), %0d responses checked",
               words_sent, key_settings, PLAN_ROWS, responses_checked);
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("%0d failures", fail_count);
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

`default_nettype wire
